@@ hdl/hsd_pkg.sv @@
package hsd_pkg;

    // Field widths
    localparam int CW_W   = 63;
    localparam int DATA_W = 57;
    localparam int LEN_W  = 6;

    // Codeword length limits and reset value
    localparam logic [LEN_W-1:0] MIN_LEN   = 6'd3;
    localparam logic [LEN_W-1:0] RESET_LEN = 6'd7;

    // Depth of the queue between front and back
    localparam int QDEPTH = 2;

    // APB register map
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic REG_CW_LEN = 1'b0;   // word index of codeword_length

    // One classified, corrected codeword on its way to the back end
    typedef struct packed {
        logic [CW_W-1:0]  word;
        logic [LEN_W-1:0] count;
        logic [LEN_W-1:0] synd;
        logic             corrected;
        logic             bad;
    } t_hsd_entry;

    // Drop the power-of-two positions and pack the rest in ascending order
    function automatic logic [DATA_W-1:0] compact(input logic [CW_W-1:0] w);
        logic [DATA_W-1:0] d;
        int                k;
        d = '0;
        k = 0;
        for (int q = 1; q <= CW_W; q++) begin
            if ((q & (q - 1)) != 0) begin
                d[k[5:0]] = w[q-1];
                k++;
            end
        end
        return d;
    endfunction

endpackage

@@ hdl/hsd_ifs.sv @@
interface hsd_in_if;
    logic                     valid;
    logic                     ready;
    logic [hsd_pkg::CW_W-1:0] codeword;

    modport source (output valid, output codeword, input ready);
    modport sink   (input valid, input codeword, output ready);
endinterface

interface hsd_out_if;
    logic                       valid;
    logic                       ready;
    logic [hsd_pkg::DATA_W-1:0] data_bits;
    logic [hsd_pkg::LEN_W-1:0]  data_count;
    logic [hsd_pkg::LEN_W-1:0]  syndrome;
    logic                       corrected;
    logic                       bad_syndrome;

    modport source (output valid, output data_bits, output data_count, output syndrome,
                    output corrected, output bad_syndrome, input ready);
    modport sink   (input valid, input data_bits, input data_count, input syndrome,
                    input corrected, input bad_syndrome, output ready);
endinterface

@@ hdl/hsd_front.sv @@
module hsd_front #(
    parameter int MAX_CODEWORD_BITS = 63
) (
    input  logic [hsd_pkg::LEN_W-1:0] i_len,
    input  logic                      i_valid,
    input  logic [hsd_pkg::CW_W-1:0]  i_codeword,
    output logic                      o_ready,
    input  logic                      i_q_ready,
    output logic                      o_push,
    output hsd_pkg::t_hsd_entry       o_entry
);
    localparam logic [hsd_pkg::LEN_W-1:0] MAX_LEN = hsd_pkg::LEN_W'(MAX_CODEWORD_BITS);

    logic [hsd_pkg::LEN_W-1:0] n_len;
    logic [hsd_pkg::LEN_W-1:0] n_pow;
    logic [hsd_pkg::CW_W-1:0]  n_word;
    logic [hsd_pkg::LEN_W-1:0] n_synd;
    logic                      n_bad;
    logic                      n_fix;

    // Clamp the programmed length to the supported range
    always_comb begin
        n_len = i_len;
        if (n_len < hsd_pkg::MIN_LEN) n_len = hsd_pkg::MIN_LEN;
        if (n_len > MAX_LEN)          n_len = MAX_LEN;
        n_pow = 6'd2 + 6'(n_len >= 6'd4) + 6'(n_len >= 6'd8) + 6'(n_len >= 6'd16)
              + 6'(n_len >= 6'd32);
    end

    // Mask off positions beyond the length and form the syndrome
    always_comb begin
        for (int k = 0; k < hsd_pkg::CW_W; k++) begin
            n_word[k] = i_codeword[k] & (k < int'(n_len));
        end
        n_synd = '0;
        for (int q = 1; q <= hsd_pkg::CW_W; q++) begin
            if (n_word[q-1]) n_synd = n_synd ^ hsd_pkg::LEN_W'(q);
        end
        n_bad = n_synd > n_len;
        n_fix = (n_synd != '0) && !n_bad;
    end

    always_comb begin
        o_entry.word      = n_word;
        if (n_fix) o_entry.word[n_synd - 6'd1] = ~n_word[n_synd - 6'd1];
        o_entry.count     = n_len - n_pow;
        o_entry.synd      = n_synd;
        o_entry.corrected = n_fix;
        o_entry.bad       = n_bad;
    end

    assign o_ready = i_q_ready;
    assign o_push  = i_valid & i_q_ready;

endmodule

@@ hdl/hsd_queue.sv @@
module hsd_queue #(
    parameter int DEPTH = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  hsd_pkg::t_hsd_entry i_entry,
    output logic                o_ready,
    input  logic                i_pop,
    output logic                o_valid,
    output hsd_pkg::t_hsd_entry o_entry
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    hsd_pkg::t_hsd_entry r_mem [DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) n_wr = (r_wr == LAST) ? '0 : r_wr + 1'b1;
        if (i_pop)  n_rd = (r_rd == LAST) ? '0 : r_rd + 1'b1;
        if (i_push && !i_pop) n_cnt = r_cnt + 1'b1;
        if (!i_push && i_pop) n_cnt = r_cnt - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_entry;
    end

    assign o_ready = r_cnt != CW'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_entry = r_mem[r_rd];

endmodule

@@ hdl/hsd_back.sv @@
module hsd_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  hsd_pkg::t_hsd_entry i_entry,
    output logic                o_pop,
    hsd_out_if.source           o_res
);
    logic                       r_valid;
    logic [hsd_pkg::DATA_W-1:0] r_bits;
    logic [hsd_pkg::LEN_W-1:0]  r_count;
    logic [hsd_pkg::LEN_W-1:0]  r_synd;
    logic                       r_corr;
    logic                       r_bad;

    // Advance when the output slot is empty or being taken
    assign o_pop = i_valid & (!r_valid | o_res.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_bits  <= hsd_pkg::compact(i_entry.word);
            r_count <= i_entry.count;
            r_synd  <= i_entry.synd;
            r_corr  <= i_entry.corrected;
            r_bad   <= i_entry.bad;
        end
    end

    assign o_res.valid        = r_valid;
    assign o_res.data_bits    = r_bits;
    assign o_res.data_count   = r_count;
    assign o_res.syndrome     = r_synd;
    assign o_res.corrected    = r_corr;
    assign o_res.bad_syndrome = r_bad;

endmodule

@@ hdl/hamming_sec_decoder_core.sv @@
// Channel  | Dir | Payload                                              | Handshake
// ---------+-----+------------------------------------------------------+------------
// i_cw     | in  | codeword[62:0]                                       | valid/ready
// o_res    | out | data_bits[56:0] data_count syndrome corrected bad_syn | valid/ready
// APB      | in  | codeword_length at byte address 0                    | psel/penable
//
// Throughput: one item per cycle unless o_res stalls; o_res.valid rises once the item
// has passed through the queue and the output register.
// The front end masks, forms the syndrome and corrects in the accept cycle; the
// result then passes through the two-entry queue and the output register.
// Reset (synchronous, i_rst_n low): queue and output empty, codeword_length = 7.
// i_cw.ready drops only when the queue is full; a stall on o_res backs up
// through the queue without losing an item.
module hamming_sec_decoder_core #(
    parameter int MAX_CODEWORD_BITS = 63
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    hsd_in_if.sink                       i_cw,
    hsd_out_if.source                    o_res,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [hsd_pkg::APB_AW-1:0]   paddr,
    input  logic [hsd_pkg::APB_DW-1:0]   pwdata,
    output logic [hsd_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);
    logic [hsd_pkg::LEN_W-1:0] r_len;
    logic                      cfg_sel;

    logic                      fe_push;
    logic                      q_ready;
    logic                      q_valid;
    logic                      q_pop;
    hsd_pkg::t_hsd_entry       fe_entry;
    hsd_pkg::t_hsd_entry       q_entry;

    // Configuration: word index comes from paddr[2]; other words are ignored
    assign cfg_sel = paddr[2] == hsd_pkg::REG_CW_LEN;
    assign pready  = 1'b1;
    assign prdata  = cfg_sel ? hsd_pkg::APB_DW'(r_len) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= hsd_pkg::RESET_LEN;
        end else if (psel && penable && pwrite && pready && cfg_sel) begin
            r_len <= pwdata[hsd_pkg::LEN_W-1:0];
        end
    end

    // Front end: clamp length, build syndrome, flip the bad bit
    hsd_front #(
        .MAX_CODEWORD_BITS(MAX_CODEWORD_BITS)
    ) u_front (
        .i_len      (r_len),
        .i_valid    (i_cw.valid),
        .i_codeword (i_cw.codeword),
        .o_ready    (i_cw.ready),
        .i_q_ready  (q_ready),
        .o_push     (fe_push),
        .o_entry    (fe_entry)
    );

    // Decouple the two ends so each can stall on its own
    hsd_queue #(
        .DEPTH(hsd_pkg::QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fe_push),
        .i_entry (fe_entry),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_entry (q_entry)
    );

    // Back end: strip parity positions and hold the result until taken
    hsd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_entry (q_entry),
        .o_pop   (q_pop),
        .o_res   (o_res)
    );

`ifndef NO_ASSERTIONS
    // A word is either corrected or flagged, never both
    a_corr_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> !(o_res.corrected && o_res.bad_syndrome))
        else $error("corrected and bad_syndrome both set");

    // Any correction or flag needs a nonzero syndrome
    a_synd_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.corrected || o_res.bad_syndrome)) |-> o_res.syndrome != '0)
        else $error("correction or flag with zero syndrome");

    // An accepted word reaches the queue, so the queue is not empty next cycle
    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cw.valid && i_cw.ready) |=> q_valid)
        else $error("accepted item missing from queue");
`endif

endmodule

@@ verif/hamming_sec_decoder_core_test.sv @@
`timescale 1ns / 100ps

module hamming_sec_decoder_core_test;

    // Byte addresses on the APB port: register 0 is codeword_length,
    // the next word is unmapped and must not disturb anything.
    localparam logic [hsd_pkg::APB_AW-1:0] CW_LEN_ADDR =
        hsd_pkg::APB_AW'({hsd_pkg::REG_CW_LEN, 2'b00});
    localparam logic [hsd_pkg::APB_AW-1:0] SPARE_ADDR  = hsd_pkg::APB_AW'(4);

    // Cycles without any accepted item before the run is declared hung.
    // It sits well above the longest gap or stall pick_gap can draw plus a drain's settling.
    localparam int unsigned HANG_LIMIT = 2000;

    // Random part: phases of items, each at its own codeword length
    localparam int unsigned PHASES     = 10;
    localparam int unsigned PHASE_SIZE = 65;

    // One decoded result, laid out like the o_res payload
    typedef struct packed {
        logic [hsd_pkg::DATA_W-1:0] data_bits;
        logic [hsd_pkg::LEN_W-1:0]  data_count;
        logic [hsd_pkg::LEN_W-1:0]  syndrome;
        logic                       corrected;
        logic                       bad_syndrome;
    } t_decoded;

    logic i_clk;
    logic i_rst_n;

    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [hsd_pkg::APB_AW-1:0] paddr;
    logic [hsd_pkg::APB_DW-1:0] pwdata;
    logic [hsd_pkg::APB_DW-1:0] prdata;
    logic                       pready;

    hsd_in_if  cw_if ();
    hsd_out_if res_if ();

    hamming_sec_decoder_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cw    (cw_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Codewords waiting to be offered, and decoded results waiting to arrive
    logic [hsd_pkg::CW_W-1:0] codeword_q [$];
    t_decoded                 decoded_q [$];

    // Shadow of codeword_length as the block should hold it
    logic [hsd_pkg::LEN_W-1:0] cur_len;

    // Set for phases that run with no gaps and no stalls at all
    bit no_idle;

    int unsigned mismatches;
    int unsigned gap_left;
    int unsigned stall_left;
    int unsigned idle_cycles;

    wire cw_fire  = cw_if.valid && cw_if.ready;
    wire res_fire = res_if.valid && res_if.ready;
    wire apb_fire = psel && penable && pready;

    // Toggle the clock every half period (20 ns period)
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Length the block actually works with: below three counts as three
    function automatic int unsigned eff_length(input logic [hsd_pkg::LEN_W-1:0] len);
        return (len < hsd_pkg::MIN_LEN) ? int'(hsd_pkg::MIN_LEN) : int'(len);
    endfunction

    // Even-parity checks over the first n positions, failing checks summed
    function automatic logic [hsd_pkg::LEN_W-1:0] parity_syndrome(
        input logic [hsd_pkg::CW_W-1:0] w,
        input int unsigned n);
        logic [hsd_pkg::LEN_W-1:0] s;
        logic                      par;
        s = '0;
        for (int unsigned p = 1; p <= n; p = p * 2) begin
            par = 1'b0;
            for (int unsigned q = 1; q <= n; q++) begin
                if ((q & p) != 0)
                    par ^= w[q-1];
            end
            if (par)
                s |= hsd_pkg::LEN_W'(p);
        end
        return s;
    endfunction

    // Decode one codeword at the given register setting
    function automatic t_decoded decode_codeword(input logic [hsd_pkg::CW_W-1:0] cw,
                                                 input logic [hsd_pkg::LEN_W-1:0] len);
        t_decoded                 r;
        int unsigned              n;
        int unsigned              k;
        logic [63:0]              mask;
        logic [hsd_pkg::CW_W-1:0] word;
        n    = eff_length(len);
        mask = (64'd1 << n) - 64'd1;
        word = cw & mask[hsd_pkg::CW_W-1:0];
        r    = '0;
        r.syndrome = parity_syndrome(word, n);
        if (r.syndrome != '0) begin
            if (r.syndrome <= n) begin
                word[r.syndrome - 1'b1] = ~word[r.syndrome - 1'b1];
                r.corrected = 1'b1;
            end else begin
                r.bad_syndrome = 1'b1;
            end
        end
        k = 0;
        for (int unsigned q = 1; q <= n; q++) begin
            if ((q & (q - 1)) != 0) begin
                r.data_bits[k] = word[q-1];
                k++;
            end
        end
        r.data_count = hsd_pkg::LEN_W'(k);
        return r;
    endfunction

    function automatic logic [hsd_pkg::CW_W-1:0] random_bits();
        return hsd_pkg::CW_W'({$urandom, $urandom});
    endfunction

    // Random data with the parity positions set so every check passes;
    // bits above the length stay random and must be ignored
    function automatic logic [hsd_pkg::CW_W-1:0] clean_codeword(input int unsigned n);
        logic [hsd_pkg::CW_W-1:0]  w;
        logic [hsd_pkg::LEN_W-1:0] s;
        w = random_bits();
        for (int unsigned p = 1; p <= n; p = p * 2)
            w[p-1] = 1'b0;
        s = parity_syndrome(w, n);
        for (int unsigned p = 1; p <= n; p = p * 2) begin
            if ((s & p) != 0)
                w[p-1] = 1'b1;
        end
        return w;
    endfunction

    // Mostly clean or single-error words, some double errors and raw noise
    function automatic logic [hsd_pkg::CW_W-1:0] random_codeword(input int unsigned n);
        logic [hsd_pkg::CW_W-1:0] w;
        int unsigned              a;
        int unsigned              b;
        int unsigned              pick;
        w    = clean_codeword(n);
        pick = $urandom_range(0, 9);
        a    = $urandom_range(1, n);
        b    = $urandom_range(1, n);
        if (pick >= 4 && pick <= 7)
            w[a-1] = ~w[a-1];
        else if (pick == 8) begin
            w[a-1] = ~w[a-1];
            if (b != a)
                w[b-1] = ~w[b-1];
        end else if (pick == 9)
            w = random_bits();
        return w;
    endfunction

    // Gap or stall length: mostly none, often short, now and then long
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    // Write one register: setup cycle, then access cycle until pready
    task automatic apb_write(input logic [hsd_pkg::APB_AW-1:0] addr,
                             input logic [hsd_pkg::APB_DW-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == CW_LEN_ADDR)
            cur_len = data[hsd_pkg::LEN_W-1:0];
    endtask

    // Hold until every queued item went in and every result came out,
    // then leave the pipeline time to settle; sample between
    // edges so the driver's updates have landed
    task automatic drain();
        do @(negedge i_clk);
        while (codeword_q.size() != 0 || cw_if.valid || decoded_q.size() != 0);
        repeat (6) @(posedge i_clk);
    endtask

    // Driver: offer queued codewords, record the expected result on accept
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cw_if.valid    <= 1'b0;
            cw_if.codeword <= '0;
            gap_left       <= 0;
        end else begin
            if (cw_fire)
                decoded_q.push_back(decode_codeword(cw_if.codeword, cur_len));
            // Advance only when nothing is held or the held item just went in
            if (!cw_if.valid || cw_fire) begin
                if (gap_left != 0) begin
                    gap_left    <= gap_left - 1;
                    cw_if.valid <= 1'b0;
                end else if (codeword_q.size() != 0) begin
                    cw_if.valid    <= 1'b1;
                    cw_if.codeword <= codeword_q.pop_front();
                    gap_left       <= pick_gap();
                end else begin
                    cw_if.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: stall at random, compare each accepted result with the oldest one due
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            stall_left   <= 0;
        end else begin
            if (res_fire) begin
                if (decoded_q.size() == 0) begin
                    $display("%0t: result with nothing due: data=%h cnt=%0d syn=%0d cor=%b bad=%b",
                             $time, res_if.data_bits, res_if.data_count, res_if.syndrome,
                             res_if.corrected, res_if.bad_syndrome);
                    mismatches++;
                end else begin
                    t_decoded due;
                    t_decoded got;
                    due = decoded_q.pop_front();
                    got = '{res_if.data_bits, res_if.data_count, res_if.syndrome,
                            res_if.corrected, res_if.bad_syndrome};
                    if (got !== due) begin
                        $display("%0t: mismatch exp data=%h cnt=%0d syn=%0d cor=%b bad=%b",
                                 $time, due.data_bits, due.data_count, due.syndrome,
                                 due.corrected, due.bad_syndrome);
                        $display("%0t:          act data=%h cnt=%0d syn=%0d cor=%b bad=%b",
                                 $time, got.data_bits, got.data_count, got.syndrome,
                                 got.corrected, got.bad_syndrome);
                        mismatches++;
                    end
                end
            end
            if (stall_left != 0) begin
                stall_left   <= stall_left - 1;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
                stall_left   <= ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
            end
        end
    end

    // Watchdog: drop the run if no item moves on any port for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || cw_fire || res_fire || apb_fire)
            idle_cycles <= 0;
        else if (idle_cycles >= HANG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        logic [hsd_pkg::LEN_W-1:0] len;
        // Drive every input to a known value before the first edge
        i_rst_n        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        cw_if.valid    = 1'b0;
        cw_if.codeword = '0;
        res_if.ready   = 1'b0;
        cur_len        = hsd_pkg::RESET_LEN;
        no_idle        = 1'b0;
        mismatches     = 0;
        idle_cycles    = 0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset length of seven: clean words, stray bits above the length,
        // and single errors on parity and data positions
        codeword_q.push_back('0);
        codeword_q.push_back({hsd_pkg::CW_W{1'b1}});
        codeword_q.push_back({{(hsd_pkg::CW_W-7){1'b1}}, 7'b0});
        codeword_q.push_back(hsd_pkg::CW_W'(1) << 0);
        codeword_q.push_back(hsd_pkg::CW_W'(1) << 2);
        codeword_q.push_back(hsd_pkg::CW_W'(1) << 3);
        codeword_q.push_back(hsd_pkg::CW_W'(1) << 6);
        drain();

        // Length zero with upper register bits set: the block must run at three
        apb_write(CW_LEN_ADDR, 32'hFFFF_FFC0);
        codeword_q.push_back(hsd_pkg::CW_W'(3'b111));
        codeword_q.push_back(hsd_pkg::CW_W'(3'b100));
        codeword_q.push_back(hsd_pkg::CW_W'(3'b001));
        drain();

        // Length five: a syndrome of six points past the end and is flagged
        apb_write(CW_LEN_ADDR, 32'h0000_0005);
        codeword_q.push_back(hsd_pkg::CW_W'(5'b01010));
        codeword_q.push_back(hsd_pkg::CW_W'(5'b10000));
        drain();

        // Full length, then a write to the unmapped word that must change nothing
        apb_write(CW_LEN_ADDR, 32'hFFFF_FFFF);
        apb_write(SPARE_ADDR, 32'h0000_0005);
        codeword_q.push_back({hsd_pkg::CW_W{1'b1}});
        codeword_q.push_back('0);
        codeword_q.push_back(hsd_pkg::CW_W'(1) << (hsd_pkg::CW_W - 1));
        codeword_q.push_back(clean_codeword(hsd_pkg::CW_W));
        codeword_q.push_back(clean_codeword(hsd_pkg::CW_W) ^ (hsd_pkg::CW_W'(1) << 31));
        drain();

        // Random phases: extremes and the reset length first, then arbitrary register values
        for (int unsigned ph = 0; ph < PHASES; ph++) begin
            if (ph == 0)
                len = hsd_pkg::LEN_W'(hsd_pkg::CW_W);
            else if (ph == 1)
                len = hsd_pkg::MIN_LEN;
            else if (ph == 2)
                len = hsd_pkg::LEN_W'(1);
            else if (ph == 3)
                len = hsd_pkg::RESET_LEN;
            else
                len = hsd_pkg::LEN_W'($urandom_range(0, 63));
            no_idle = (ph == 4) || (ph != 5 && $urandom_range(0, 3) == 0);
            apb_write(CW_LEN_ADDR, hsd_pkg::APB_DW'({$urandom, len}));
            for (int unsigned i = 0; i < PHASE_SIZE; i++)
                codeword_q.push_back(random_codeword(eff_length(cur_len)));
            drain();
        end

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
